// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLKRST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/mfhp_pkg.sv
// ----------------------------------------------------------------------------
// mfhp_pkg
// Types, codes and rate tables of the MP3 frame header parser.
// ----------------------------------------------------------------------------
package mfhp_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [15:0] HUNT_LIMIT_RESET = 16'd31744;

   localparam logic [1:0] ST_HEADER = 2'd0;
   localparam logic [1:0] ST_TAG    = 2'd1;
   localparam logic [1:0] ST_LIMIT  = 2'd2;
   localparam logic [1:0] ST_END    = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  b2;
      logic [7:0]  b3;
      logic [7:0]  b4;
      logic [15:0] crc;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  mpeg_version;
      logic [18:0] bit_rate;
      logic [15:0] sample_rate;
      logic [4:0]  header_flags;
      logic [1:0]  channel_mode;
      logic [1:0]  mode_extension;
      logic [1:0]  emphasis_code;
      logic [15:0] crc_word;
      logic [10:0] payload_bytes;
      logic [10:0] main_data_bytes;
   } result_type;

   function automatic logic [18:0] rate_hi(input logic [3:0] idx);
      logic [18:0] r;
      unique case (idx)
         4'd1:    r = 19'd32000;
         4'd2:    r = 19'd40000;
         4'd3:    r = 19'd48000;
         4'd4:    r = 19'd56000;
         4'd5:    r = 19'd64000;
         4'd6:    r = 19'd80000;
         4'd7:    r = 19'd96000;
         4'd8:    r = 19'd112000;
         4'd9:    r = 19'd128000;
         4'd10:   r = 19'd160000;
         4'd11:   r = 19'd192000;
         4'd12:   r = 19'd224000;
         4'd13:   r = 19'd256000;
         4'd14:   r = 19'd320000;
         default: r = 19'd0;
      endcase
      return r;
   endfunction

   function automatic logic [18:0] rate_lo(input logic [3:0] idx);
      logic [18:0] r;
      unique case (idx)
         4'd1:    r = 19'd8000;
         4'd2:    r = 19'd16000;
         4'd3:    r = 19'd24000;
         4'd4:    r = 19'd32000;
         4'd5:    r = 19'd40000;
         4'd6:    r = 19'd48000;
         4'd7:    r = 19'd56000;
         4'd8:    r = 19'd64000;
         4'd9:    r = 19'd80000;
         4'd10:   r = 19'd96000;
         4'd11:   r = 19'd112000;
         4'd12:   r = 19'd128000;
         4'd13:   r = 19'd144000;
         4'd14:   r = 19'd160000;
         default: r = 19'd0;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] srate(input logic [1:0] row, input logic [1:0] sidx);
      logic [15:0] r;
      unique case ({row, sidx})
         4'b00_00: r = 16'd44100;
         4'b00_01: r = 16'd48000;
         4'b00_10: r = 16'd32000;
         4'b01_00: r = 16'd22050;
         4'b01_01: r = 16'd24000;
         4'b01_10: r = 16'd16000;
         4'b10_00: r = 16'd11025;
         4'b10_01: r = 16'd12000;
         4'b10_10: r = 16'd8000;
         default:  r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

// File: design/mfhp_req_if.sv
// ----------------------------------------------------------------------------
// mfhp_req_if
// Byte channel into the parser: valid, ready, one stream byte and a stream-end mark.
// ----------------------------------------------------------------------------
interface mfhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_end;

   modport source (output valid, data_byte, stream_end, input ready);
   modport sink (input valid, data_byte, stream_end, output ready);
endinterface

// File: design/mfhp_rsp_if.sv
// ----------------------------------------------------------------------------
// mfhp_rsp_if
// Result channel out of the parser: valid, ready and one report.
// ----------------------------------------------------------------------------
interface mfhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [1:0]  mpeg_version;
   logic [18:0] bit_rate;
   logic [15:0] sample_rate;
   logic [4:0]  header_flags;
   logic [1:0]  channel_mode;
   logic [1:0]  mode_extension;
   logic [1:0]  emphasis_code;
   logic [15:0] crc_word;
   logic [10:0] payload_bytes;
   logic [10:0] main_data_bytes;

   modport source (output valid, status, mpeg_version, bit_rate, sample_rate, header_flags,
                   channel_mode, mode_extension, emphasis_code, crc_word, payload_bytes,
                   main_data_bytes, input ready);
   modport sink (input valid, status, mpeg_version, bit_rate, sample_rate, header_flags,
                 channel_mode, mode_extension, emphasis_code, crc_word, payload_bytes,
                 main_data_bytes, output ready);
endinterface

// File: design/mfhp_queue.sv
// ----------------------------------------------------------------------------
// mfhp_queue
// Short register queue of classified events between front and back.
// ----------------------------------------------------------------------------
module mfhp_queue
   import mfhp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// File: design/mfhp_front.sv
// ----------------------------------------------------------------------------
// mfhp_front
// Byte-rate parse sequencer: sync hunt, tag handling, header capture.
// ----------------------------------------------------------------------------
module mfhp_front
   import mfhp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   mfhp_req_if.sink    req_bus,
   input  logic        full,
   output push_type    push
);

   localparam logic [3:0] PH_HUNT   = 4'd0;
   localparam logic [3:0] PH_TAG    = 4'd1;
   localparam logic [3:0] PH_ID3    = 4'd2;
   localparam logic [3:0] PH_ID3HDR = 4'd3;
   localparam logic [3:0] PH_SKIP   = 4'd4;
   localparam logic [3:0] PH_HDR2   = 4'd5;
   localparam logic [3:0] PH_HDR3   = 4'd6;
   localparam logic [3:0] PH_HDR4   = 4'd7;
   localparam logic [3:0] PH_CRC1   = 4'd8;
   localparam logic [3:0] PH_CRC2   = 4'd9;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] CH_T      = 8'h54;
   localparam logic [7:0] CH_A      = 8'h41;
   localparam logic [7:0] CH_G      = 8'h47;
   localparam logic [7:0] CH_I      = 8'h49;
   localparam logic [7:0] CH_D      = 8'h44;
   localparam logic [7:0] CH_3      = 8'h33;

   function automatic logic [5:0] cand(input logic [7:0] b);
      logic [5:0] r;
      if (b == SYNC_BYTE) begin
         r = {PH_HDR2, 2'd0};
      end else if (b == CH_T) begin
         r = {PH_TAG, 2'd1};
      end else if (b == CH_I) begin
         r = {PH_ID3, 2'd1};
      end else begin
         r = {PH_HUNT, 2'd0};
      end
      return r;
   endfunction

   logic [3:0]  phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [1:0]  mprog_ff, mprog_in;
   logic [3:0]  tfc_ff, tfc_in;
   logic [27:0] skip_ff, skip_in;
   logic [15:0] limit_ff;
   logic [7:0]  b2_ff, b2_in, b3_ff, b3_in, b4_ff, b4_in, crc_hi_ff, crc_hi_in;

   logic        accept, counted, emit;
   logic [16:0] inc;
   logic [5:0]  cnd;
   logic [3:0]  tfc_v;
   logic [27:0] skip_v;
   logic [7:0]  b;
   entry_type   ent;

   assign b            = req_bus.data_byte;
   assign req_bus.ready = !full;
   assign accept       = req_bus.valid && !full;
   assign inc          = {1'b0, count_ff} + 17'd1;
   assign cnd          = cand(b);
   assign counted      = (phase_ff == PH_HUNT) || (phase_ff == PH_TAG) ||
                         (phase_ff == PH_ID3) || (phase_ff == PH_HDR2) ||
                         (phase_ff == PH_HDR3) || (phase_ff > PH_CRC2);
   assign push.valid   = accept && emit;
   assign push.entry   = ent;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      mprog_in   = mprog_ff;
      tfc_in     = tfc_ff;
      skip_in    = skip_ff;
      b2_in      = b2_ff;
      b3_in      = b3_ff;
      b4_in      = b4_ff;
      crc_hi_in  = crc_hi_ff;
      emit       = 1'b0;
      ent.status = ST_HEADER;
      ent.b2     = b2_ff;
      ent.b3     = b3_ff;
      ent.b4     = b4_ff;
      ent.crc    = '0;
      tfc_v      = tfc_ff + 4'd1;
      skip_v     = skip_ff;

      if (counted && (inc > {1'b0, limit_ff})) begin
         emit       = 1'b1;
         ent.status = ST_LIMIT;
         phase_in   = PH_HUNT;
         count_in   = '0;
         mprog_in   = '0;
      end else begin
         if (counted) begin
            count_in = inc[15:0];
         end
         unique case (phase_ff)
            PH_TAG: begin
               if (mprog_ff == 2'd1 && b == CH_A) begin
                  mprog_in = 2'd2;
               end else if (mprog_ff == 2'd2 && b == CH_G) begin
                  emit       = 1'b1;
                  ent.status = ST_TAG;
                  phase_in   = PH_HUNT;
                  count_in   = '0;
                  mprog_in   = '0;
               end else begin
                  {phase_in, mprog_in} = cnd;
               end
            end
            PH_ID3: begin
               if (mprog_ff == 2'd1 && b == CH_D) begin
                  mprog_in = 2'd2;
               end else if (mprog_ff == 2'd2 && b == CH_3) begin
                  phase_in = PH_ID3HDR;
                  mprog_in = '0;
                  tfc_in   = '0;
                  skip_in  = '0;
               end else begin
                  {phase_in, mprog_in} = cnd;
               end
            end
            PH_ID3HDR: begin
               if (tfc_ff >= 4'd3) begin
                  skip_v = {skip_ff[20:0], b[6:0]};
               end
               skip_in = skip_v;
               if (tfc_v >= 4'd7) begin
                  tfc_in   = '0;
                  phase_in = (skip_v != '0) ? PH_SKIP : PH_HUNT;
               end else begin
                  tfc_in = tfc_v;
               end
            end
            PH_SKIP: begin
               if (skip_ff != '0) begin
                  skip_v = skip_ff - 28'd1;
               end
               skip_in = skip_v;
               if (skip_v == '0) begin
                  phase_in = PH_HUNT;
               end
            end
            PH_HDR2: begin
               if (b[7:5] == 3'b111 && b[4:3] != 2'b01 && b[2:1] == 2'b01) begin
                  b2_in    = b;
                  phase_in = PH_HDR3;
               end else begin
                  {phase_in, mprog_in} = cnd;
               end
            end
            PH_HDR3: begin
               if (b[7:4] == 4'd0 || b[7:4] == 4'd15 || b[3:2] == 2'd3) begin
                  {phase_in, mprog_in} = cnd;
               end else begin
                  b3_in    = b;
                  phase_in = PH_HDR4;
               end
            end
            PH_HDR4: begin
               b4_in = b;
               if (!b2_ff[0]) begin
                  phase_in = PH_CRC1;
               end else begin
                  emit     = 1'b1;
                  ent.b4   = b;
                  phase_in = PH_HUNT;
                  count_in = '0;
                  mprog_in = '0;
               end
            end
            PH_CRC1: begin
               crc_hi_in = b;
               phase_in  = PH_CRC2;
            end
            PH_CRC2: begin
               emit     = 1'b1;
               ent.crc  = {crc_hi_ff, b};
               phase_in = PH_HUNT;
               count_in = '0;
               mprog_in = '0;
            end
            default: begin
               {phase_in, mprog_in} = cnd;
            end
         endcase
      end

      if (req_bus.stream_end) begin
         if (!emit) begin
            emit       = 1'b1;
            ent.status = ST_END;
         end
         phase_in  = PH_HUNT;
         count_in  = '0;
         mprog_in  = '0;
         tfc_in    = '0;
         skip_in   = '0;
         crc_hi_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         mprog_ff <= '0;
         tfc_ff   <= '0;
         skip_ff  <= '0;
         limit_ff <= HUNT_LIMIT_RESET;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            mprog_ff <= mprog_in;
            tfc_ff   <= tfc_in;
            skip_ff  <= skip_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b2_ff     <= b2_in;
         b3_ff     <= b3_in;
         b4_ff     <= b4_in;
         crc_hi_ff <= crc_hi_in;
      end
   end

endmodule

// File: design/mfhp_back.sv
// ----------------------------------------------------------------------------
// mfhp_back
// Header decode, frame length division and result register.
// ----------------------------------------------------------------------------
module mfhp_back
   import mfhp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  entry_type head,
   output logic      pop,
   mfhp_rsp_if.source rsp_bus
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_DIV  = 2'd1;
   localparam logic [1:0] B_DONE = 2'd2;

   localparam int DIV_STEPS = 26;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   logic [1:0]        state_ff, state_in;
   entry_type         ent_ff, ent_in;
   logic [18:0]       br_ff, br_in;
   logic [15:0]       sr_ff, sr_in;
   logic [DIV_STEPS-1:0] quo_ff, quo_in;
   logic [15:0]       rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, out_in;

   logic        out_free;
   logic [1:0]  hver, hrow;
   logic [18:0] hbr;
   logic [15:0] hsr;
   logic [7:0]  hk;
   logic [26:0] prod;
   logic [16:0] trial;
   logic        ge;
   logic        prot, pad;
   logic [26:0] frame, ovh, payload, side, mainlen;

   assign out_free = !out_valid_ff || rsp_bus.ready;

   assign hver = head.b2[4:3];
   assign hrow = (hver == 2'd3) ? 2'd0 : ((hver == 2'd2) ? 2'd1 : 2'd2);
   assign hbr  = (hver == 2'd3) ? rate_hi(head.b3[7:4]) : rate_lo(head.b3[7:4]);
   assign hsr  = srate(hrow, head.b3[3:2]);
   assign hk   = (hver == 2'd3) ? 8'd144 : 8'd72;
   assign prod = 27'(hk) * 27'(hbr);

   assign trial = {rem_ff, quo_ff[DIV_STEPS-1]};
   assign ge    = (trial >= {1'b0, sr_ff});

   assign prot    = !ent_ff.b2[0];
   assign pad     = ent_ff.b3[1];
   assign frame   = (sr_ff == '0) ? '0 : ({1'b0, quo_ff} + 27'(pad));
   assign ovh     = prot ? 27'd6 : 27'd4;
   assign payload = (frame > ovh) ? (frame - ovh) : '0;
   assign side    = (ent_ff.b2[4:3] == 2'd3) ? ((ent_ff.b4[7:6] == 2'd3) ? 27'd17 : 27'd32)
                                             : ((ent_ff.b4[7:6] == 2'd3) ? 27'd9 : 27'd17);
   assign mainlen = (payload > side) ? (payload - side) : '0;

   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      br_in        = br_ff;
      sr_in        = sr_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      pop          = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (head_valid) begin
               if (head.status != ST_HEADER) begin
                  if (out_free) begin
                     pop          = 1'b1;
                     out_in       = '0;
                     out_in.status = head.status;
                     out_valid_in = 1'b1;
                  end
               end else begin
                  pop      = 1'b1;
                  ent_in   = head;
                  br_in    = hbr;
                  sr_in    = hsr;
                  quo_in   = prod[DIV_STEPS-1:0];
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = B_DIV;
               end
            end
         end
         B_DIV: begin
            rem_in  = ge ? 16'(trial - {1'b0, sr_ff}) : trial[15:0];
            quo_in  = {quo_ff[DIV_STEPS-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (out_free) begin
               out_in.status          = ST_HEADER;
               out_in.mpeg_version    = ent_ff.b2[4:3];
               out_in.bit_rate        = br_ff;
               out_in.sample_rate     = sr_ff;
               out_in.header_flags    = {ent_ff.b4[2], ent_ff.b4[3], ent_ff.b3[0], pad, prot};
               out_in.channel_mode    = ent_ff.b4[7:6];
               out_in.mode_extension  = ent_ff.b4[5:4];
               out_in.emphasis_code   = ent_ff.b4[1:0];
               out_in.crc_word        = prot ? ent_ff.crc : '0;
               out_in.payload_bytes   = payload[10:0];
               out_in.main_data_bytes = mainlen[10:0];
               out_valid_in           = 1'b1;
               state_in               = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      br_ff   <= br_in;
      sr_ff   <= sr_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      out_ff  <= out_in;
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.status          = out_ff.status;
   assign rsp_bus.mpeg_version    = out_ff.mpeg_version;
   assign rsp_bus.bit_rate        = out_ff.bit_rate;
   assign rsp_bus.sample_rate     = out_ff.sample_rate;
   assign rsp_bus.header_flags    = out_ff.header_flags;
   assign rsp_bus.channel_mode    = out_ff.channel_mode;
   assign rsp_bus.mode_extension  = out_ff.mode_extension;
   assign rsp_bus.emphasis_code   = out_ff.emphasis_code;
   assign rsp_bus.crc_word        = out_ff.crc_word;
   assign rsp_bus.payload_bytes   = out_ff.payload_bytes;
   assign rsp_bus.main_data_bytes = out_ff.main_data_bytes;

endmodule

// File: design/mp3_frame_header_parser_core.sv
// ----------------------------------------------------------------------------
// mp3_frame_header_parser_core
// MPEG audio layer III frame header parser, one stream byte per transfer.
//
// req_bus carries one stream byte and a stream-end mark per transfer. The
// front sequencer takes a byte every cycle while its event queue has room,
// hunts for sync, skips ID3v2 tags and captures header bytes. Each byte that
// yields a report (header, TAG marker, hunt limit, stream end) pushes one
// event into the queue. The back end pops events and drives rsp_bus from an
// output register, so new bytes are taken while a result waits.
// A status report passes through the queue and the output register; a header
// report also goes through table lookup and multiply, 26 steps of a radix-2
// divider for the frame length and the length arithmetic. The back end takes
// no new event until a header is finished; other reports drain at one per
// cycle while rsp_bus is ready.
// csr_wr_en writes the hunt limit from csr_wr_data.
// Reset clears the parse state, the queue and the output valid flag and loads
// the hunt limit default. While rsp_bus stalls the queue fills and then
// req_bus.ready drops until the back end frees a place.
// ----------------------------------------------------------------------------
module mp3_frame_header_parser_core
   import mfhp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   mfhp_req_if.sink    req_bus,
   mfhp_rsp_if.source  rsp_bus
);

   push_type  push;
   logic      full, pop, head_valid;
   entry_type head;

   mfhp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .full        (full),
      .push        (push)
   );

   mfhp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   mfhp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

// File: design/mfhp_checker.sv
// ----------------------------------------------------------------------------
// mfhp_checker
// Port-level assertions on the parser's result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfhp_checker
   import mfhp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  status,
   input logic [18:0] bit_rate,
   input logic [15:0] sample_rate,
   input logic [10:0] payload_bytes,
   input logic [10:0] main_data_bytes
);

   `ASSERT_CLKRST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   `ASSERT_CLKRST(a_status_zero, clock, reset, rsp_valid && status != ST_HEADER |-> bit_rate == '0 && sample_rate == '0 && payload_bytes == '0 && main_data_bytes == '0, "status report carries header fields")

   `ASSERT_CLKRST(a_header_sane, clock, reset, rsp_valid && status == ST_HEADER |-> bit_rate != '0 && sample_rate != '0 && main_data_bytes <= payload_bytes, "header report out of range")

   `ASSERT_CLK(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "result valid right after reset")

endmodule

bind mp3_frame_header_parser_core mfhp_checker u_mfhp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .status          (rsp_bus.status),
   .bit_rate        (rsp_bus.bit_rate),
   .sample_rate     (rsp_bus.sample_rate),
   .payload_bytes   (rsp_bus.payload_bytes),
   .main_data_bytes (rsp_bus.main_data_bytes)
);
